>>> src/bdrs_pkg.sv
// shared types and constants of the block-decomposed range sum core
// no dependencies
package bdrs_pkg;

  localparam int MaxElements = 1024;
  localparam int BlockSize   = 32;
  localparam int NumBlocks   = (MaxElements + BlockSize - 1) / BlockSize;
  localparam int IdxW        = $clog2(MaxElements);
  localparam int CntW        = $clog2(MaxElements + 1);
  localparam int BlkW        = $clog2(NumBlocks);
  localparam int OffW        = $clog2(BlockSize);
  localparam int ValW        = 32;
  localparam int SumW        = 42;
  localparam int QDepth      = 2;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_QARR   = 2'd1,
    CMD_QSORT  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
    logic [10:0]        range_first;
    logic [10:0]        range_last;
  } in_item_t;

  typedef struct packed {
    logic signed [41:0] range_sum;
    logic               range_error;
  } out_item_t;

  // classified job handed from front to back
  // lo can reach the element count itself for an empty range at the top
  typedef struct packed {
    cmd_t               cmd;
    logic               err;
    logic signed [31:0] value;
    logic [CntW-1:0]    lo;
    logic [CntW-1:0]    hi;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INS,
    ST_CLR,
    ST_Q_RD,
    ST_Q_ACC,
    ST_OUT
  } bk_state_t;

endpackage

>>> src/block_decomposed_range_sum_core.sv
// top level of the block-decomposed range sum core
// depends on bdrs_pkg, bdrs_front, bdrs_back
//
// channel | dir | payload
// in_     | in  | in_item_t  (command, value, range_first, range_last)
// out_    | out | out_item_t (range_sum, range_error)
//
// load: appends the value and shifts larger sorted elements up to insert it
// query: adds edge elements one by one and whole aligned blocks from their block sums
// clear: zeroes count and block sums; a two-entry job queue lets input run ahead of the back end
// reset clears the element count and block sums; the result waits in place while out_ready is low
module block_decomposed_range_sum_core
  import bdrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic job_valid, job_ready;
  job_t job;

  bdrs_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .job_valid, .job_ready, .job
  );

  bdrs_back u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job,
    .out_valid, .out_ready, .out_data
  );

endmodule

>>> src/bdrs_front.sv
// front end: checks the range of queries and queues classified jobs
// depends on bdrs_pkg; tracks element count alongside the back end
module bdrs_front
  import bdrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     job_valid,
  input  logic     job_ready,
  output job_t     job
);

  job_t            q_r [QDepth];
  logic [0:0]      wp_r, rp_r;
  logic [1:0]      cnt_r;
  logic [CntW-1:0] count_r, count_nxt;
  job_t            j;
  logic            push, pop;
  logic [11:0]     last_p1;

  assign in_ready  = (cnt_r != 2'(QDepth));
  assign push      = in_valid && in_ready;
  assign job_valid = (cnt_r != 2'd0);
  assign pop       = job_valid && job_ready;
  assign job       = q_r[rp_r];

  always_comb begin
    last_p1   = {1'b0, in_data.range_last} + 12'd1;
    j.cmd     = cmd_t'(in_data.command);
    j.value   = in_data.value;
    j.lo      = CntW'(in_data.range_first - 11'd1);
    j.hi      = CntW'(in_data.range_last);
    j.err     = (in_data.range_first == 11'd0) ||
                (CntW'(in_data.range_last) > count_r) ||
                ({1'b0, in_data.range_first} > last_p1);
    count_nxt = count_r;
    case (j.cmd)
      CMD_LOAD:  if (count_r != CntW'(MaxElements)) count_nxt = count_r + 1'b1;
      CMD_CLEAR: count_nxt = '0;
      default:   count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      cnt_r   <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wp_r    <= wp_r + 1'b1;
        count_r <= count_nxt;
      end
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= j;
  end

endmodule

>>> src/bdrs_back.sv
// back end: value stores, block sums, sorted insert and query walk
// depends on bdrs_pkg
module bdrs_back
  import bdrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_ready,
  input  job_t      job,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic signed [ValW-1:0] arr_mem [MaxElements];
  logic signed [ValW-1:0] srt_mem [MaxElements];
  logic signed [SumW-1:0] abs_r [NumBlocks];
  logic signed [SumW-1:0] sbs_r [NumBlocks];

  bk_state_t st_r, st_nxt;
  job_t      jb_r;
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] pos_r, pos_nxt;
  logic signed [ValW-1:0] rd_r;
  logic signed [SumW-1:0] acc_r, acc_nxt;
  logic [CntW-1:0] qi_r, qi_nxt;
  logic            rsel_r;
  logic [CntW-1:0] rd_addr;
  logic            take, step_blk;
  logic [BlkW-1:0] qblk;

  assign job_ready = (st_r == ST_IDLE);
  assign take      = job_valid && job_ready;
  assign qblk      = qi_r[IdxW-1:OffW];
  // whole block may be used when aligned and fully inside the range
  assign step_blk  = (qi_r[OffW-1:0] == '0) && (qi_r + CntW'(BlockSize) <= jb_r.hi);

  always_comb begin
    st_nxt  = st_r;
    pos_nxt = pos_r;
    acc_nxt = acc_r;
    qi_nxt  = qi_r;
    rd_addr = pos_r - 1'b1;
    case (st_r)
      ST_IDLE: begin
        if (take) begin
          case (job.cmd)
            CMD_LOAD:  st_nxt = (count_r == CntW'(MaxElements)) ? ST_IDLE : ST_SRCH;
            CMD_CLEAR: st_nxt = ST_CLR;
            default: begin
              acc_nxt = '0;
              qi_nxt  = CntW'(job.lo);
              st_nxt  = job.err ? ST_OUT : ST_Q_RD;
            end
          endcase
          pos_nxt = count_r;
        end
      end
      // read sorted[pos-1]; data lands in rd_r next cycle
      ST_SRCH:     st_nxt = (pos_r == '0) ? ST_INS : ST_SHIFT_RD;
      ST_SHIFT_RD: begin
        if (rd_r > jb_r.value) st_nxt = ST_SHIFT_WR;
        else st_nxt = ST_INS;
      end
      ST_SHIFT_WR: begin
        pos_nxt = pos_r - 1'b1;
        st_nxt  = ST_SRCH;
      end
      ST_INS:  st_nxt = ST_IDLE;
      ST_CLR:  st_nxt = ST_IDLE;
      ST_Q_RD: begin
        rd_addr = qi_r;
        if (qi_r >= jb_r.hi) st_nxt = ST_OUT;
        else if (step_blk) begin
          acc_nxt = acc_r + (rsel_r ? sbs_r[qblk] : abs_r[qblk]);
          qi_nxt  = qi_r + CntW'(BlockSize);
        end else st_nxt = ST_Q_ACC;
      end
      ST_Q_ACC: begin
        acc_nxt = acc_r + SumW'(rd_r);
        qi_nxt  = qi_r + 1'b1;
        st_nxt  = ST_Q_RD;
      end
      ST_OUT:  if (out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_valid          = (st_r == ST_OUT);
  assign out_data.range_sum = jb_r.err ? '0 : acc_r;
  assign out_data.range_error = jb_r.err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      count_r <= '0;
      for (int k = 0; k < NumBlocks; k++) begin
        abs_r[k] <= '0;
        sbs_r[k] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLR) begin
        count_r <= '0;
        for (int k = 0; k < NumBlocks; k++) begin
          abs_r[k] <= '0;
          sbs_r[k] <= '0;
        end
      end
      if (st_r == ST_IDLE && take && job.cmd == CMD_LOAD && count_r != CntW'(MaxElements))
        abs_r[count_r[IdxW-1:OffW]] <= abs_r[count_r[IdxW-1:OffW]] + SumW'(job.value);
      // moving an element up crosses into the next block at a boundary
      if (st_r == ST_SHIFT_WR && pos_r[OffW-1:0] == '0) begin
        sbs_r[pos_r[IdxW-1:OffW]]       <= sbs_r[pos_r[IdxW-1:OffW]] + SumW'(rd_r);
        sbs_r[pos_r[IdxW-1:OffW] - 1'b1] <= sbs_r[pos_r[IdxW-1:OffW] - 1'b1] - SumW'(rd_r);
      end
      if (st_r == ST_INS) begin
        sbs_r[pos_r[IdxW-1:OffW]] <= sbs_r[pos_r[IdxW-1:OffW]] + SumW'(jb_r.value);
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    acc_r <= acc_nxt;
    qi_r  <= qi_nxt;
    if (take) begin
      jb_r   <= job;
      // loads walk the sorted store as well
      rsel_r <= (job.cmd != CMD_QARR);
    end
    rd_r <= rsel_r ? srt_mem[rd_addr[IdxW-1:0]] : arr_mem[rd_addr[IdxW-1:0]];
  end

  // value stores
  always_ff @(posedge clk) begin
    if (take && job.cmd == CMD_LOAD && count_r != CntW'(MaxElements))
      arr_mem[count_r[IdxW-1:0]] <= job.value;
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_SHIFT_WR) srt_mem[pos_r[IdxW-1:0]] <= rd_r;
    else if (st_r == ST_INS && pos_r != CntW'(MaxElements))
      srt_mem[pos_r[IdxW-1:0]] <= jb_r.value;
  end

endmodule
